FILE: src/lsf_pkg.sv
// Shared types, constants and helpers for the line substring filter.
`default_nettype none
package lsf_pkg;

	localparam int KEY_MAX = 16;
	localparam int KEY_IDX_W = $clog2(KEY_MAX);
	localparam int LEN_W = 5;
	localparam int BYTE_W = 8;
	localparam int WORD_W = 64;
	localparam int CFG_IDX_W = 3;

	localparam logic [BYTE_W-1:0] ASCII_UPPER_A = 8'h41;
	localparam logic [BYTE_W-1:0] ASCII_UPPER_Z = 8'h5A;
	localparam logic [BYTE_W-1:0] CASE_OFFSET = 8'h20;

	// Indexes four and up name no register; writes to them are dropped.
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_KEY_FIRST  = 3'd0,
		CFG_KEY_LAST   = 3'd1,
		CFG_KEY_LENGTH = 3'd2,
		CFG_IGNORE_CASE = 3'd3
	} cfg_reg_t;

	// Control broadcast from the top level to every cell of the chain.
	typedef struct packed {
		logic advance;
		logic flush;
		logic fold;
	} lsf_ctrl_t;

	function automatic logic [BYTE_W-1:0] fold_byte(input logic [BYTE_W-1:0] b,
		input logic fold);
		logic [BYTE_W-1:0] r;
		r = b;
		if (fold && (b inside {[ASCII_UPPER_A:ASCII_UPPER_Z]})) begin
			r = b + CASE_OFFSET;
		end
		return r;
	endfunction

endpackage
`default_nettype wire

FILE: src/lsf_cell.sv
// One cell of the shift-and prefix chain: tracks whether key bytes 0..i end here.
`default_nettype none
module lsf_cell
	import lsf_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire lsf_ctrl_t         ctrl,
	input  wire logic [BYTE_W-1:0] key_byte,
	input  wire logic [BYTE_W-1:0] text_byte,
	input  wire logic              enable,
	input  wire logic              prev_hit,
	output logic                   hit
);

	logic hit_q;
	logic match;

	assign match = (fold_byte(key_byte, ctrl.fold) == text_byte);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else if (ctrl.flush) begin
			hit_q <= 1'b0;
		end else if (ctrl.advance) begin
			hit_q <= prev_hit & enable & match;
		end
	end

	assign hit = hit_q;

endmodule
`default_nettype wire

FILE: src/line_substring_filter_top.sv
// Top level of the line substring filter: config registers, cell chain and verdict register.
`default_nettype none
// Takes one text beat per clock, characters and line ends alike, with no bubbles.
// Each key byte owns one cell of a shift-and chain, so a character updates all
// prefix states together; the verdict for a line is registered and shows
// in the cycle after its line-end beat is taken. Text is only held off when a
// line-end beat arrives while an earlier verdict is still stalled. An empty key
// matches every line, and a key length above sixteen counts as sixteen.
module line_substring_filter_top
	import lsf_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 text_valid,
	output logic                      text_stall,
	input  wire logic [BYTE_W-1:0]    text_byte,
	input  wire logic                 line_end,
	output logic                      verdict_valid,
	input  wire logic                 verdict_stall,
	output logic                      line_matched,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [WORD_W-1:0]    cfg_data
);

	logic [WORD_W-1:0] key_first_q;
	logic [WORD_W-1:0] key_last_q;
	logic [LEN_W-1:0]  key_length_q;
	logic              ignore_case_q;

	logic [LEN_W-1:0]      len_used;
	logic [KEY_IDX_W-1:0]  top_idx;
	logic [2*WORD_W-1:0]   key_all;
	logic [BYTE_W-1:0]     text_folded;
	logic [KEY_MAX-1:0]    hits;
	logic                  top_hit;
	logic                  found_q;
	logic                  accept;
	logic                  verdict_valid_q;
	logic                  line_matched_q;
	lsf_ctrl_t             ctrl;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_first_q   <= '0;
			key_last_q    <= '0;
			key_length_q  <= '0;
			ignore_case_q <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_reg_t'(cfg_index))
				CFG_KEY_FIRST:   key_first_q   <= cfg_data;
				CFG_KEY_LAST:    key_last_q    <= cfg_data;
				CFG_KEY_LENGTH:  key_length_q  <= cfg_data[LEN_W-1:0];
				CFG_IGNORE_CASE: ignore_case_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign len_used = (key_length_q > LEN_W'(KEY_MAX)) ? LEN_W'(KEY_MAX) : key_length_q;
	assign top_idx = KEY_IDX_W'(len_used - LEN_W'(1));
	assign key_all = {key_last_q, key_first_q};
	assign text_folded = fold_byte(text_byte, ignore_case_q);

	// A line-end beat can only be refused while the previous verdict is still stalled.
	assign text_stall = verdict_valid_q & verdict_stall & line_end;
	assign accept = text_valid & ~text_stall;

	assign ctrl.advance = accept & ~line_end;
	assign ctrl.flush = accept & line_end;
	assign ctrl.fold = ignore_case_q;

	for (genvar i = 0; i < KEY_MAX; i++) begin : g_cell
		lsf_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl),
			.key_byte  (key_all[i*BYTE_W +: BYTE_W]),
			.text_byte (text_folded),
			.enable    (LEN_W'(i) < len_used),
			.prev_hit  ((i == 0) ? 1'b1 : hits[(i == 0) ? 0 : i-1]),
			.hit       (hits[i])
		);
	end

	// The top cell's state after each character is folded into the sticky
	// flag on the next character beat; the verdict also looks at the current top cell.
	assign top_hit = (len_used != '0) & hits[top_idx];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (ctrl.flush) begin
			found_q <= 1'b0;
		end else if (ctrl.advance) begin
			found_q <= found_q | top_hit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			verdict_valid_q <= 1'b0;
		end else if (ctrl.flush) begin
			verdict_valid_q <= 1'b1;
		end else if (!verdict_stall) begin
			verdict_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.flush) begin
			line_matched_q <= (len_used == '0) | found_q | top_hit;
		end
	end

	assign verdict_valid = verdict_valid_q;
	assign line_matched = line_matched_q;

`ifndef SYNTH
	a_flush_clears_chain: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.flush |=> (hits == '0) && !found_q)
		else $error("prefix chain not cleared after line end");

	a_empty_key_matches: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.flush && key_length_q == '0) |=> verdict_valid && line_matched)
		else $error("empty key did not match line");

	a_verdict_after_line_end: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.flush |=> verdict_valid)
		else $error("line end beat produced no verdict");
`endif

endmodule
`default_nettype wire
